[sv/tpt_pkg.sv]
// tpt_pkg: shared widths, defaults and types for the tlb page translator
// no dependencies; imported by tpt_tlb and tlb_page_translator
package tpt_pkg;

	// address split
	localparam int ADDR_W   = 16;
	localparam int PAGE_W   = 8;
	localparam int OFFSET_W = 8;
	localparam int FRAME_W  = 8;

	// page index space that an 8-bit page number can reach
	localparam int PAGE_SPAN = 1 << PAGE_W;

	// frame allocator and statistics
	localparam int FREE_W = 9;
	localparam logic [FREE_W-1:0] FREE_MAX = '1;
	localparam int CNT_W = 32;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// parameter defaults
	localparam int DEF_TLB_ENTRIES = 32;
	localparam int DEF_PAGE_COUNT  = 256;

	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [FRAME_W-1:0] frame_t;

	// tlb fill request
	typedef struct packed {
		logic   en;
		page_t  page;
		frame_t frame;
	} tlb_ins_t;

endpackage

[sv/tpt_ram.sv]
// tpt_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module tpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                      wr_data,
	input  logic                                  rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/tpt_tlb.sv]
// tpt_tlb: fully associative tlb with parallel match and fifo replacement
// depends on tpt_pkg
module tpt_tlb
	import tpt_pkg::*;
#(
	parameter int ENTRIES = DEF_TLB_ENTRIES
) (
	input  logic     clk,
	input  logic     arst_n,
	input  page_t    lookup_page,
	input  tlb_ins_t ins,
	output logic     hit,
	output frame_t   hit_frame
);

	localparam int PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic             valid_q [ENTRIES];
	page_t            page_q  [ENTRIES];
	frame_t           frame_q [ENTRIES];
	logic [PTR_W-1:0] ptr_q;

	// parallel match; a page is held in at most one entry, so an or of the
	// matching frames gives the hit frame
	always_comb begin
		hit       = 1'b0;
		hit_frame = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (valid_q[i] && (page_q[i] == lookup_page)) begin
				hit       = 1'b1;
				hit_frame = hit_frame | frame_q[i];
			end
		end
	end

	// valid bits and fifo pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (ins.en) begin
			valid_q[ptr_q] <= 1'b1;
			if (ptr_q == PTR_W'(ENTRIES - 1)) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		if (ins.en) begin
			page_q[ptr_q]  <= ins.page;
			frame_q[ptr_q] <= ins.frame;
		end
	end

endmodule

[sv/tlb_page_translator.sv]
// tlb_page_translator: logical to physical address translation with page map and tlb
// depends on tpt_pkg, tpt_ram, tpt_tlb
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+--------------------------------------------
//  addr     | addr_valid / addr_stall   | logical_address
//  result   | result_valid / result_stall | physical_address, tlb_hit, page_fault,
//           |                           | hit_count, access_count
//
// one item per cycle sustained while the result is not stalled; an item passes from stage 1 into the result register.
// stage 1 holds the item while the page map RAM read completes; tlb match, frame
// allocation and map/tlb updates happen as the item moves into the result register.
// reset clears all page map and tlb valid bits at once; no clearing pass is needed.
// a stalled result holds stage 1, which then stalls the addr channel.
module tlb_page_translator
	import tpt_pkg::*;
#(
	parameter int TLB_ENTRIES = DEF_TLB_ENTRIES,
	parameter int PAGE_COUNT  = DEF_PAGE_COUNT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                addr_valid,
	output logic                addr_stall,
	input  logic [ADDR_W-1:0]   logical_address,
	output logic                result_valid,
	input  logic                result_stall,
	output logic [ADDR_W-1:0]   physical_address,
	output logic                tlb_hit,
	output logic                page_fault,
	output logic [CNT_W-1:0]    hit_count,
	output logic [CNT_W-1:0]    access_count
);

	// only indices an 8-bit page can reach get storage
	localparam int MAP_DEPTH = (PAGE_COUNT < PAGE_SPAN) ? PAGE_COUNT : PAGE_SPAN;
	localparam int IDX_W     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

	typedef logic [IDX_W-1:0] idx_tab_t [PAGE_SPAN];

	// page to map index (page modulo page count), built at elaboration
	function automatic idx_tab_t build_idx_tab();
		idx_tab_t tab;
		int       r;
		r = 0;
		for (int i = 0; i < PAGE_SPAN; i++) begin
			tab[i] = IDX_W'(r);
			r      = r + 1;
			if (r == PAGE_COUNT) begin
				r = 0;
			end
		end
		return tab;
	endfunction

	localparam idx_tab_t IDX_TAB = build_idx_tab();

	// stage 1 registers
	logic               item_valid_s1;
	page_t              page_s1;
	logic [OFFSET_W-1:0] offset_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               mapped_s1;
	logic               fwd_s1;
	frame_t             fwd_frame_s1;

	// state
	logic               map_valid_q [MAP_DEPTH];
	logic [FREE_W-1:0]  next_free_q;
	logic [CNT_W-1:0]   hit_cnt_q;
	logic [CNT_W-1:0]   access_cnt_q;

	// result registers
	logic               result_valid_q;
	logic [ADDR_W-1:0]  phys_q;
	logic               hit_q;
	logic               fault_q;

	logic               accept;
	logic               fire;
	page_t              in_page;
	logic [IDX_W-1:0]   in_idx;
	logic               map_wr;
	logic               in_fwd;
	frame_t             new_frame;
	frame_t             map_frame;
	frame_t             ram_frame;
	logic               tlb_match;
	frame_t             tlb_frame;
	logic               hit;
	frame_t             frame;
	tlb_ins_t           tlb_ins;

	// flow control
	assign fire       = item_valid_s1 && (!result_valid_q || !result_stall);
	assign addr_stall = item_valid_s1 && !fire;
	assign accept     = addr_valid && !addr_stall;

	// incoming item decode and page map write forwarding
	assign in_page   = logical_address[ADDR_W-1:OFFSET_W];
	assign in_idx    = IDX_TAB[in_page];
	assign map_wr    = fire && !mapped_s1;
	assign in_fwd    = map_wr && (idx_s1 == in_idx);
	assign new_frame = next_free_q[FRAME_W-1:0];

	tpt_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (MAP_DEPTH)
	) u_map_ram (
		.clk     (clk),
		.wr_en   (map_wr),
		.wr_addr (idx_s1),
		.wr_data (new_frame),
		.rd_en   (accept),
		.rd_addr (in_idx),
		.rd_data (ram_frame)
	);

	tpt_tlb #(
		.ENTRIES (TLB_ENTRIES)
	) u_tlb (
		.clk         (clk),
		.arst_n      (arst_n),
		.lookup_page (page_s1),
		.ins         (tlb_ins),
		.hit         (tlb_match),
		.hit_frame   (tlb_frame)
	);

	// translation for the item in stage 1
	always_comb begin
		map_frame = fwd_s1 ? fwd_frame_s1 : ram_frame;
		hit       = mapped_s1 && tlb_match;
		if (!mapped_s1) begin
			frame = new_frame;
		end else if (tlb_match) begin
			frame = tlb_frame;
		end else begin
			frame = map_frame;
		end
		tlb_ins.en    = fire && !hit;
		tlb_ins.page  = page_s1;
		tlb_ins.frame = frame;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1  <= 1'b0;
			result_valid_q <= 1'b0;
			next_free_q    <= '0;
			hit_cnt_q      <= '0;
			access_cnt_q   <= '0;
			for (int i = 0; i < MAP_DEPTH; i++) begin
				map_valid_q[i] <= 1'b0;
			end
		end else begin
			if (accept) begin
				item_valid_s1 <= 1'b1;
			end else if (fire) begin
				item_valid_s1 <= 1'b0;
			end
			if (fire) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (map_wr) begin
				map_valid_q[idx_s1] <= 1'b1;
				if (next_free_q != FREE_MAX) begin
					next_free_q <= next_free_q + 1'b1;
				end
			end
			if (fire) begin
				if (access_cnt_q != CNT_MAX) begin
					access_cnt_q <= access_cnt_q + 1'b1;
				end
				if (hit && (hit_cnt_q != CNT_MAX)) begin
					hit_cnt_q <= hit_cnt_q + 1'b1;
				end
			end
		end
	end

	// stage 1 and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			page_s1      <= in_page;
			offset_s1    <= logical_address[OFFSET_W-1:0];
			idx_s1       <= in_idx;
			mapped_s1    <= map_valid_q[in_idx] || in_fwd;
			fwd_s1       <= in_fwd;
			fwd_frame_s1 <= new_frame;
		end
		if (fire) begin
			phys_q  <= {frame, offset_s1};
			hit_q   <= hit;
			fault_q <= !mapped_s1;
		end
	end

	// counters change only when a result loads, so they stand as result fields
	assign result_valid     = result_valid_q;
	assign physical_address = phys_q;
	assign tlb_hit          = hit_q;
	assign page_fault       = fault_q;
	assign hit_count        = hit_cnt_q;
	assign access_count     = access_cnt_q;

endmodule
